/* src/scwm_pkg.sv */
// Package for the sigma-clipped window mean block.
// Holds field widths, queue sizing and the back-end state type; no dependencies.
package scwm_pkg;

    localparam int FIELD_W = 16;   // width of the coordinate fields on the ports
    localparam int KEPT_W  = 4;    // width of the kept-count field

    // Request queue between front and back end (depth must stay a power of two)
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Pipeline depth of one window pass: read data, n*p, |d|, d^2, (n-1)*d^2
    localparam int PASS_STAGES = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DEV,
        ST_TEST,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

/* src/scwm_in_if.sv */
// Input channel of the sigma-clipped window mean block: valid/ready and one point.
// Depends on scwm_pkg.
interface scwm_in_if
    import scwm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  point_x;
    logic signed [FIELD_W-1:0]  point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

/* src/scwm_out_if.sv */
// Result channel of the sigma-clipped window mean block: valid/ready and one result.
// Depends on scwm_pkg.
interface scwm_out_if
    import scwm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  smooth_x;
    logic signed [FIELD_W-1:0]  smooth_y;
    logic [KEPT_W-1:0]          kept_count;
    logic                       used_fallback;

    modport source (output valid, output smooth_x, output smooth_y,
                    output kept_count, output used_fallback, input ready);
    modport sink   (input valid, input smooth_x, input smooth_y,
                    input kept_count, input used_fallback, output ready);
endinterface

/* src/sigma_clipped_window_mean_2d.sv */
// Sigma-clipped window mean of 2D points, top level; depends on scwm_pkg, the channel
// interfaces, scwm_front and scwm_back. Each request is served by three passes over the
// window RAM read port and a bit-serial divider. The back end takes the next request
// only after it has loaded the last result into the result register; a two-deep queue
// and the result register let each side stall. Reset clears counts, pointers and
// valids.
module sigma_clipped_window_mean_2d
    import scwm_pkg::*;
#(
    parameter int WINDOW     = 10,
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    scwm_in_if.sink     point,
    scwm_out_if.source  result
);
    localparam int VW = (COORD_BITS > FIELD_W) ? FIELD_W + 1 : COORD_BITS;

    logic                 q_valid;
    logic                 q_ready;
    logic signed [VW-1:0] q_x;
    logic signed [VW-1:0] q_y;

    scwm_front #(
        .COORD_BITS (COORD_BITS),
        .VW         (VW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_x     (q_x),
        .q_y     (q_y)
    );

    scwm_back #(
        .WINDOW (WINDOW),
        .VW     (VW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_x     (q_x),
        .q_y     (q_y),
        .result  (result)
    );
endmodule

/* src/scwm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/scwm_front.sv */
// Front end: accepts points, narrows them to COORD_BITS (zero-extends them when wider) and queues them.
// Depends on scwm_pkg and scwm_in_if.
module scwm_front
    import scwm_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int VW         = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    scwm_in_if.sink               point,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic signed [VW-1:0]  q_x,
    output logic signed [VW-1:0]  q_y
);
    logic signed [VW-1:0] ext_x;
    logic signed [VW-1:0] ext_y;
    logic signed [VW-1:0] slot_x_reg [QDEPTH];
    logic signed [VW-1:0] slot_y_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic                 push;
    logic                 pop;

    // Wider coordinate formats see the 16-bit field as an unsigned value
    if (COORD_BITS > FIELD_W)
    begin : g_zext
        assign ext_x = signed'({1'b0, point.point_x});
        assign ext_y = signed'({1'b0, point.point_y});
    end
    else
    begin : g_sext
        assign ext_x = signed'(point.point_x[VW-1:0]);
        assign ext_y = signed'(point.point_y[VW-1:0]);
    end

    assign point.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push        = point.valid && point.ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_valid && q_ready;
    assign q_x         = slot_x_reg[rd_ptr_reg];
    assign q_y         = slot_y_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_x_reg[wr_ptr_reg] <= ext_x;
            slot_y_reg[wr_ptr_reg] <= ext_y;
        end
    end
endmodule

/* src/scwm_div.sv */
// Two-lane restoring divider: signed numerators over a shared positive divisor,
// quotient truncated toward zero, one bit per cycle. No package dependencies.
module scwm_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num_x,
    input  logic signed [NUM_W-1:0]  num_y,
    input  logic [DEN_W-1:0]         den,
    output logic                     done,
    output logic signed [NUM_W-1:0]  quo_x,
    output logic signed [NUM_W-1:0]  quo_y
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_x_reg;
    logic [DEN_W-1:0]    rem_y_reg;
    logic [NUM_W-1:0]    quo_x_reg;
    logic [NUM_W-1:0]    quo_y_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    logic [DEN_W:0]      step_x;
    logic [DEN_W:0]      step_y;

    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic msb,
                                                input logic [DEN_W-1:0] d);
        logic [DEN_W:0] trial;
        trial = {rem, msb};
        if (trial >= {1'b0, d})
        begin
            div_step = {DEN_W'(trial - {1'b0, d}), 1'b1};
        end
        else
        begin
            div_step = {trial[DEN_W-1:0], 1'b0};
        end
    endfunction

    function automatic logic [NUM_W-1:0] magnitude(input logic signed [NUM_W-1:0] v);
        magnitude = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    endfunction

    assign step_x = div_step(rem_x_reg, quo_x_reg[NUM_W-1], den_reg);
    assign step_y = div_step(rem_y_reg, quo_y_reg[NUM_W-1], den_reg);

    assign done  = done_reg;
    assign quo_x = neg_x_reg ? -signed'(quo_x_reg) : signed'(quo_x_reg);
    assign quo_y = neg_y_reg ? -signed'(quo_y_reg) : signed'(quo_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg   <= den;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            quo_x_reg <= magnitude(num_x);
            quo_y_reg <= magnitude(num_y);
            neg_x_reg <= num_x[NUM_W-1];
            neg_y_reg <= num_y[NUM_W-1];
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit into the remainder, the quotient bit in at the bottom
            rem_x_reg <= step_x[DEN_W:1];
            rem_y_reg <= step_y[DEN_W:1];
            quo_x_reg <= {quo_x_reg[NUM_W-2:0], step_x[0]};
            quo_y_reg <= {quo_y_reg[NUM_W-2:0], step_y[0]};
        end
    end
endmodule

/* src/scwm_back.sv */
// Back end: stores each point in the window RAM, makes three passes (sums, squared
// deviations, clipping test), divides and holds the result. Depends on scwm_pkg,
// scwm_out_if, scwm_ram and scwm_div.
module scwm_back
    import scwm_pkg::*;
#(
    parameter int WINDOW = 10,
    parameter int VW     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic signed [VW-1:0]  q_x,
    input  logic signed [VW-1:0]  q_y,
    scwm_out_if.source            result
);
    localparam int NB = $clog2(WINDOW + 1);   // holds a count up to WINDOW
    localparam int IW = $clog2(WINDOW);       // RAM index
    localparam int SW = VW + NB;              // sums and n*p
    localparam int QW = 2 * SW;               // squared deviation
    localparam int TW = QW + NB;              // sum of squares, (n-1)*d^2

    back_state_t state_reg;
    back_state_t state_next;

    logic [NB-1:0]           fill_reg;
    logic [NB-1:0]           fill_next;
    logic [IW-1:0]           slot_reg;
    logic [IW-1:0]           slot_next;
    logic [NB-1:0]           n_reg;
    logic [NB-1:0]           idx_reg;
    logic [PASS_STAGES-1:0]  vld_reg;

    logic                    start_item;
    logic                    pass_active;
    logic                    issue;
    logic                    pass_done;
    logic                    div_start;
    logic                    div_done;
    logic                    out_free;
    logic                    load_out;

    logic [2*VW-1:0]         rdata;
    logic signed [VW-1:0]    rd_x;
    logic signed [VW-1:0]    rd_y;

    logic signed [SW-1:0]    sx_reg;
    logic signed [SW-1:0]    sy_reg;
    logic signed [SW-1:0]    kx_reg;
    logic signed [SW-1:0]    ky_reg;
    logic [NB-1:0]           kept_reg;
    logic [TW-1:0]           totx_reg;
    logic [TW-1:0]           toty_reg;

    logic signed [SW-1:0]    n_s;
    logic [NB-1:0]           nm1;
    logic signed [SW-1:0]    npx_reg;
    logic signed [SW-1:0]    npy_reg;
    logic signed [SW:0]      dx;
    logic signed [SW:0]      dy;
    logic [SW-1:0]           magx_reg;
    logic [SW-1:0]           magy_reg;
    logic [QW-1:0]           sqx_reg;
    logic [QW-1:0]           sqy_reg;
    logic [TW-1:0]           prodx_reg;
    logic [TW-1:0]           prody_reg;
    logic signed [VW-1:0]    px_reg [1:PASS_STAGES-1];
    logic signed [VW-1:0]    py_reg [1:PASS_STAGES-1];
    logic                    pass_ok;

    logic                    fb;
    logic                    fb_reg;
    logic [KEPT_W-1:0]       kept_out_reg;
    logic signed [SW-1:0]    num_x;
    logic signed [SW-1:0]    num_y;
    logic [NB-1:0]           den;
    logic signed [SW-1:0]    quo_x;
    logic signed [SW-1:0]    quo_y;
    logic signed [31:0]      quo_x32;
    logic signed [31:0]      quo_y32;

    logic                       res_valid_reg;
    logic                       res_valid_next;
    logic signed [FIELD_W-1:0]  res_x_reg;
    logic signed [FIELD_W-1:0]  res_y_reg;
    logic [KEPT_W-1:0]          res_kept_reg;
    logic                       res_fb_reg;

    scwm_ram #(
        .WIDTH (2 * VW),
        .DEPTH (WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (start_item),
        .waddr (slot_reg),
        .wdata ({q_x, q_y}),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    scwm_div #(
        .NUM_W (SW),
        .DEN_W (NB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (num_x),
        .num_y (num_y),
        .den   (den),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    assign rd_x      = signed'(rdata[2*VW-1:VW]);
    assign rd_y      = signed'(rdata[VW-1:0]);
    assign issue     = pass_active && (idx_reg < n_reg);
    assign pass_done = pass_active && (idx_reg == n_reg) && (vld_reg == '0);
    assign out_free  = !res_valid_reg || result.ready;

    assign fill_next = (fill_reg < NB'(WINDOW)) ? fill_reg + 1'b1 : fill_reg;
    assign slot_next = (slot_reg == IW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    // Fall back to the plain mean when nothing survives (always so for one point)
    assign fb    = (kept_reg == '0);
    assign num_x = fb ? sx_reg : kx_reg;
    assign num_y = fb ? sy_reg : ky_reg;
    assign den   = fb ? n_reg : kept_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (pass_done)
                begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                if (pass_done)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (pass_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic
    always_comb
    begin
        q_ready     = 1'b0;
        start_item  = 1'b0;
        pass_active = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_ready    = 1'b1;
                start_item = q_valid;
            end
            ST_SUM, ST_DEV:
            begin
                pass_active = 1'b1;
            end
            ST_TEST:
            begin
                pass_active = 1'b1;
                div_start   = pass_done;
            end
            ST_DIV:
            begin
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            vld_reg       <= {vld_reg[PASS_STAGES-2:0], issue};
            if (start_item)
            begin
                fill_reg <= fill_next;
                slot_reg <= slot_next;
            end
            if (start_item || pass_done)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Pass pipeline: n*p, |n*p - S|, square, times (n-1)
    assign n_s     = SW'(signed'({1'b0, n_reg}));
    assign nm1     = n_reg - 1'b1;
    assign dx      = {npx_reg[SW-1], npx_reg} - {sx_reg[SW-1], sx_reg};
    assign dy      = {npy_reg[SW-1], npy_reg} - {sy_reg[SW-1], sy_reg};
    assign pass_ok = (prodx_reg < totx_reg) && (prody_reg < toty_reg);
    assign quo_x32 = 32'(quo_x);
    assign quo_y32 = 32'(quo_y);

    always_ff @(posedge clk)
    begin
        npx_reg   <= n_s * SW'(rd_x);
        npy_reg   <= n_s * SW'(rd_y);
        magx_reg  <= dx[SW] ? SW'(-dx) : SW'(dx);
        magy_reg  <= dy[SW] ? SW'(-dy) : SW'(dy);
        sqx_reg   <= QW'(magx_reg) * QW'(magx_reg);
        sqy_reg   <= QW'(magy_reg) * QW'(magy_reg);
        prodx_reg <= TW'(sqx_reg) * TW'(nm1);
        prody_reg <= TW'(sqy_reg) * TW'(nm1);
        px_reg[1] <= rd_x;
        py_reg[1] <= rd_y;
        for (int s = 2; s < PASS_STAGES; s++)
        begin
            px_reg[s] <= px_reg[s-1];
            py_reg[s] <= py_reg[s-1];
        end

        if (start_item)
        begin
            n_reg    <= fill_next;
            sx_reg   <= '0;
            sy_reg   <= '0;
            kx_reg   <= '0;
            ky_reg   <= '0;
            kept_reg <= '0;
            totx_reg <= '0;
            toty_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_SUM && vld_reg[0])
            begin
                sx_reg <= sx_reg + SW'(rd_x);
                sy_reg <= sy_reg + SW'(rd_y);
            end
            if (state_reg == ST_DEV && vld_reg[3])
            begin
                totx_reg <= totx_reg + TW'(sqx_reg);
                toty_reg <= toty_reg + TW'(sqy_reg);
            end
            // keep points that pass on both axes
            if (state_reg == ST_TEST && vld_reg[4] && pass_ok)
            begin
                kx_reg   <= kx_reg + SW'(px_reg[PASS_STAGES-1]);
                ky_reg   <= ky_reg + SW'(py_reg[PASS_STAGES-1]);
                kept_reg <= kept_reg + 1'b1;
            end
        end

        if (div_start)
        begin
            fb_reg       <= fb;
            kept_out_reg <= fb ? '0 : KEPT_W'(kept_reg);
        end

        if (load_out)
        begin
            res_x_reg    <= quo_x32[FIELD_W-1:0];
            res_y_reg    <= quo_y32[FIELD_W-1:0];
            res_kept_reg <= kept_out_reg;
            res_fb_reg   <= fb_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.smooth_x      = res_x_reg;
    assign result.smooth_y      = res_y_reg;
    assign result.kept_count    = res_kept_reg;
    assign result.used_fallback = res_fb_reg;
endmodule

/* tb/tb_top.sv */
// Testbench for sigma_clipped_window_mean_2d: drives points with random gaps and
// checks every result against a predictor of the clipped window mean it holds.
// Depends on scwm_pkg, scwm_in_if, scwm_out_if and the block itself.
module tb_top;
    import scwm_pkg::*;

    localparam int WIN     = 10;
    localparam int N_ITEMS = 1150;

    typedef struct packed {
        logic signed [FIELD_W-1:0] smooth_x;
        logic signed [FIELD_W-1:0] smooth_y;
        logic [KEPT_W-1:0]         kept_count;
        logic                      used_fallback;
    } mean_result_t;

    // Holds the window as the block should see it and the means still to arrive.
    class clipped_mean_board;
        longint       hist_x[WIN];
        longint       hist_y[WIN];
        int           fill;
        int           slot;
        mean_result_t pending_means[$];
        int           errors;
        int           clipped_seen;
        int           fallback_seen;

        function new();
            fill = 0;
            slot = 0;
            errors = 0;
            clipped_seen = 0;
            fallback_seen = 0;
        endfunction

        // Mark the stored points whose squared deviation on this axis is below the variance.
        function bit [WIN-1:0] axis_mask(longint v[WIN], int n);
            longint       s;
            longint       d;
            bit [127:0]   total;
            bit [127:0]   dsq[WIN];
            bit [WIN-1:0] m;
            s = 0;
            for (int i = 0; i < n; i++)
                s += v[i];
            total = '0;
            for (int i = 0; i < n; i++)
            begin
                d = n * v[i] - s;
                if (d < 0)
                    d = -d;
                dsq[i] = 128'(d) * 128'(d);
                total += dsq[i];
            end
            m = '0;
            for (int i = 0; i < n; i++)
                m[i] = (dsq[i] * 128'(n - 1)) < total;
            return m;
        endfunction

        function void note_point(logic signed [FIELD_W-1:0] x, logic signed [FIELD_W-1:0] y);
            longint       sx;
            longint       sy;
            longint       kx;
            longint       ky;
            longint       rx;
            longint       ry;
            int           n;
            int           kept;
            bit [WIN-1:0] keep;
            mean_result_t r;
            hist_x[slot] = x;
            hist_y[slot] = y;
            slot = (slot + 1 >= WIN) ? 0 : slot + 1;
            if (fill < WIN)
                fill++;
            n = fill;
            sx = 0;
            sy = 0;
            for (int i = 0; i < n; i++)
            begin
                sx += hist_x[i];
                sy += hist_y[i];
            end
            kx = 0;
            ky = 0;
            kept = 0;
            r.used_fallback = 1'b1;
            if (n < 2)
            begin
                rx = sx;
                ry = sy;
            end
            else
            begin
                keep = axis_mask(hist_x, n) & axis_mask(hist_y, n);
                for (int i = 0; i < n; i++)
                begin
                    if (keep[i])
                    begin
                        kx += hist_x[i];
                        ky += hist_y[i];
                        kept++;
                    end
                end
                if (kept == 0)
                begin
                    rx = sx / n;
                    ry = sy / n;
                end
                else
                begin
                    rx = kx / kept;
                    ry = ky / kept;
                    r.used_fallback = 1'b0;
                end
            end
            r.smooth_x   = rx[FIELD_W-1:0];
            r.smooth_y   = ry[FIELD_W-1:0];
            r.kept_count = kept[KEPT_W-1:0];
            pending_means.insert(pending_means.size(), r);
        endfunction

        function void check_result(mean_result_t got);
            mean_result_t want;
            if (pending_means.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
                return;
            end
            want = pending_means[0];
            pending_means.delete(0);
            if (got.used_fallback)
                fallback_seen++;
            else
                clipped_seen++;
            if (got.smooth_x !== want.smooth_x)
            begin
                $error("smooth_x: expected %0d, actual %0d", want.smooth_x, got.smooth_x);
                errors++;
            end
            if (got.smooth_y !== want.smooth_y)
            begin
                $error("smooth_y: expected %0d, actual %0d", want.smooth_y, got.smooth_y);
                errors++;
            end
            if (got.kept_count !== want.kept_count)
            begin
                $error("kept_count: expected %0d, actual %0d", want.kept_count, got.kept_count);
                errors++;
            end
            if (got.used_fallback !== want.used_fallback)
            begin
                $error("used_fallback: expected %0d, actual %0d",
                       want.used_fallback, got.used_fallback);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   sent;

    clipped_mean_board board = new();

    scwm_in_if  point_ch();
    scwm_out_if result_ch();

    sigma_clipped_window_mean_2d dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("FAIL sigma_clipped_window_mean_2d");
        $finish;
    end

    task automatic send_point(logic signed [FIELD_W-1:0] x, logic signed [FIELD_W-1:0] y);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= x;
        point_ch.point_y <= y;
        do @(posedge clk); while (!point_ch.ready);
        board.note_point(x, y);
        sent++;
    endtask

    // Hold off new requests until every pending mean has come back.
    task automatic drain_means();
        point_ch.valid <= 1'b0;
        do @(posedge clk); while (board.pending_means.size() != 0);
    endtask

    function automatic logic signed [FIELD_W-1:0] near(int c, int r);
        int v;
        v = c + int'($urandom_range(0, 2 * r)) - r;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] any_coord();
        logic [31:0] raw;
        raw = $urandom;
        return raw[FIELD_W-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return 16'sd1;
            default: return -16'sd32767;
        endcase
    endfunction

    // Drain results with a random stall before each one.
    initial
    begin
        int           stall;
        mean_result_t got;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            got.smooth_x      = result_ch.smooth_x;
            got.smooth_y      = result_ch.smooth_y;
            got.kept_count    = result_ch.kept_count;
            got.used_fallback = result_ch.used_fallback;
            board.check_result(got);
        end
    end

    initial
    begin
        int                        mode;
        int                        len;
        int                        cx;
        int                        cy;
        int                        radius;
        bit                        drained;
        logic signed [FIELD_W-1:0] px;
        logic signed [FIELD_W-1:0] py;
        rst_n            <= 1'b0;
        point_ch.valid   <= 1'b0;
        point_ch.point_x <= '0;
        point_ch.point_y <= '0;
        steady  = 1'b0;
        sent    = 0;
        drained = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single stored point, then the two opposite corners.
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);
        // Fill the whole window with one point at each extreme: once it holds only that point, nothing survives.
        repeat (WIN) send_point(16'sd32767, 16'sd32767);
        repeat (WIN) send_point(-16'sd32768, -16'sd32768);
        // Tight cluster with one far outlier.
        send_point(16'sd5, 16'sd5);
        send_point(16'sd6, 16'sd4);
        send_point(16'sd4, 16'sd6);
        send_point(16'sd5, -16'sd7);
        send_point(-16'sd30000, 16'sd30000);

        while (sent < N_ITEMS)
        begin
            mode   = $urandom_range(0, 9);
            len    = $urandom_range(5, 30);
            steady = ($urandom_range(0, 3) == 0);
            cx     = int'($urandom_range(0, 65535)) - 32768;
            cy     = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 3))
                0: radius = 0;
                1: radius = 3;
                2: radius = 100;
                default: radius = 2000;
            endcase
            for (int k = 0; k < len && sent < N_ITEMS; k++)
            begin
                if (mode < 6)
                begin
                    px = ($urandom_range(0, 7) == 0) ? any_coord() : near(cx, radius);
                    py = ($urandom_range(0, 7) == 0) ? any_coord() : near(cy, radius);
                end
                else if (mode < 8)
                begin
                    px = any_coord();
                    py = any_coord();
                end
                else if (mode == 8)
                begin
                    px = edge_coord();
                    py = edge_coord();
                end
                else
                begin
                    px = cx[FIELD_W-1:0];
                    py = cy[FIELD_W-1:0];
                end
                send_point(px, py);
            end
            if (!drained && sent > N_ITEMS / 2)
            begin
                drain_means();
                drained = 1'b1;
            end
        end
        steady = 1'b0;

        point_ch.valid <= 1'b0;
        while (board.pending_means.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (board.pending_means.size() != 0)
        begin
            $error("%0d means never arrived", board.pending_means.size());
            board.errors++;
        end

        $display("Sent %0d points; %0d results came back clipped, %0d by fallback.",
                 sent, board.clipped_seen, board.fallback_seen);
        $display("Covered clusters with outliers, full-range noise, extremes and flat windows.");
        if (board.errors == 0)
            $display("PASS sigma_clipped_window_mean_2d");
        else
            $display("FAIL sigma_clipped_window_mean_2d");
        $finish;
    end

endmodule

/* sim.f */
src/scwm_pkg.sv
src/scwm_in_if.sv
src/scwm_out_if.sv
src/scwm_ram.sv
src/scwm_front.sv
src/scwm_div.sv
src/scwm_back.sv
src/sigma_clipped_window_mean_2d.sv
tb/tb_top.sv
